### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is applied.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is applied.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ptw_pkg.sv
// Types and constants shared by the page table walker files.
`timescale 1ns / 1ps

package ptw_pkg;

  localparam int unsigned VA_W        = 48;
  localparam int unsigned PA_W        = 52;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned MB2_SHIFT   = 21;
  localparam int unsigned GB1_SHIFT   = 30;
  localparam int unsigned ENTRY_BYTES = 8;
  localparam int unsigned ENTRY_SHIFT = $clog2(ENTRY_BYTES);
  localparam int unsigned LARGE_BIT   = 7;
  localparam int unsigned PRESENT_BIT = 0;

  typedef enum logic {
    REQ_XLATE = 1'b0,
    REQ_ENTRY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } lvl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PML4,
    ST_PDPT,
    ST_PD,
    ST_PT
  } st_t;

  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] dir_base;
    logic [VA_W-1:0]   virt_addr;
    logic [WORD_W-1:0] entry_word;
  } item_t;

  typedef struct packed {
    logic [1:0]      out_kind;
    logic [PA_W-1:0] out_addr;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_bus_t;

endpackage

### rtl/ptw_if.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps

interface ptw_in_if import ptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [WORD_W-1:0] dir_base;
  logic [VA_W-1:0]   virt_addr;
  logic [WORD_W-1:0] entry_word;

  modport source (output valid, req_type, dir_base, virt_addr, entry_word, input ready);
  modport sink   (input valid, req_type, dir_base, virt_addr, entry_word, output ready);
endinterface

interface ptw_out_if import ptw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      out_kind;
  logic [PA_W-1:0] out_addr;

  modport source (output valid, out_kind, out_addr, input ready);
  modport sink   (input valid, out_kind, out_addr, output ready);
endinterface

### rtl/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker.
// One transfer is accepted per cycle unless the result channel stalls; a
// transfer passes the input register, the combinational entry decode and the
// result register. Requests that arrive while a walk is active and entry words
// that arrive while idle are consumed without a result. in_ch.ready depends
// combinationally on out_ch.ready through the result slot.
`timescale 1ns / 1ps

module four_level_page_table_walker_top import ptw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ptw_in_if.sink    in_ch,
  ptw_out_if.source out_ch
);

  logic     item_valid;
  item_t    item;
  res_bus_t res;
  logic     slot_free;
  logic     advance;

  assign advance = item_valid && (!res.valid || slot_free);

  ptw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ptw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .take  (advance),
    .res   (res)
  );

  ptw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res.valid),
    .data      (res.data),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

### rtl/ptw_in_stage.sv
// Input register of the walker: captures one transfer per cycle while it is empty or its item advances.
`timescale 1ns / 1ps

module ptw_in_stage import ptw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ptw_in_if.sink     in_ch,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt           = 1'b1;
      item_nxt.req_type   = in_ch.req_type;
      item_nxt.dir_base   = in_ch.dir_base;
      item_nxt.virt_addr  = in_ch.virt_addr;
      item_nxt.entry_word = in_ch.entry_word;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/ptw_core.sv
// Walk state machine and entry decode for one item per cycle when take is high.
`timescale 1ns / 1ps

module ptw_core import ptw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  item_t    item,
  input  logic     take,
  output res_bus_t res
);

  st_t             state_r, state_nxt;
  logic [VA_W-1:0] vaddr_r, vaddr_nxt;
  logic [WORD_W-1:0] e;

  function automatic logic [IDX_W-1:0] tbl_index(logic [VA_W-1:0] va, lvl_t lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_PML4: idx = va[PAGE_SHIFT + 3*IDX_W +: IDX_W];
      LVL_PDPT: idx = va[PAGE_SHIFT + 2*IDX_W +: IDX_W];
      LVL_PD:   idx = va[PAGE_SHIFT + IDX_W +: IDX_W];
      LVL_PT:   idx = va[PAGE_SHIFT +: IDX_W];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

  function automatic logic [PA_W-1:0] next_read(logic [WORD_W-1:0] ent,
                                                logic [VA_W-1:0] va, lvl_t lvl);
    return {ent[PA_W-1:PAGE_SHIFT], tbl_index(va, lvl), {ENTRY_SHIFT{1'b0}}};
  endfunction

  assign e = item.entry_word;

  always_comb begin
    state_nxt         = state_r;
    vaddr_nxt         = vaddr_r;
    res.valid         = 1'b0;
    res.data.out_kind = KIND_READ;
    res.data.out_addr = '0;
    if (item.req_type == REQ_XLATE) begin
      if (state_r == ST_IDLE) begin
        res.valid         = 1'b1;
        res.data.out_addr = {{(PA_W-VA_W){1'b0}}, item.dir_base[VA_W-1:PAGE_SHIFT],
                             tbl_index(item.virt_addr, LVL_PML4), {ENTRY_SHIFT{1'b0}}};
        state_nxt         = ST_PML4;
        vaddr_nxt         = item.virt_addr;
      end
    end else if (state_r != ST_IDLE) begin
      res.valid = 1'b1;
      if (!e[PRESENT_BIT]) begin
        res.data.out_kind = KIND_FAULT;
        state_nxt         = ST_IDLE;
      end else begin
        unique case (state_r)
          ST_PML4: begin
            res.data.out_addr = next_read(e, vaddr_r, LVL_PDPT);
            state_nxt         = ST_PDPT;
          end
          ST_PDPT: begin
            if (e[LARGE_BIT]) begin
              res.data.out_kind = KIND_DONE;
              res.data.out_addr = {e[PA_W-1:GB1_SHIFT], vaddr_r[GB1_SHIFT-1:0]};
              state_nxt         = ST_IDLE;
            end else begin
              res.data.out_addr = next_read(e, vaddr_r, LVL_PD);
              state_nxt         = ST_PD;
            end
          end
          ST_PD: begin
            if (e[LARGE_BIT]) begin
              res.data.out_kind = KIND_DONE;
              res.data.out_addr = {e[PA_W-1:MB2_SHIFT], vaddr_r[MB2_SHIFT-1:0]};
              state_nxt         = ST_IDLE;
            end else begin
              res.data.out_addr = next_read(e, vaddr_r, LVL_PT);
              state_nxt         = ST_PT;
            end
          end
          ST_PT: begin
            res.data.out_kind = KIND_DONE;
            res.data.out_addr = {e[PA_W-1:PAGE_SHIFT], vaddr_r[PAGE_SHIFT-1:0]};
            state_nxt         = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vaddr_r <= '0;
    end else if (take) begin
      state_r <= state_nxt;
      vaddr_r <= vaddr_nxt;
    end
  end

endmodule

### rtl/ptw_out_stage.sv
// Result register of the walker, drives the result channel.
`timescale 1ns / 1ps

module ptw_out_stage import ptw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  result_t   data,
  output logic      slot_free,
  ptw_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  assign slot_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = data;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.out_kind = data_r.out_kind;
  assign out_ch.out_addr = data_r.out_addr;

endmodule

### rtl/ptw_checker.sv
// Port-level assertions for the page table walker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptw_checker import ptw_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic [1:0]      out_kind,
  input logic [PA_W-1:0] out_addr
);

  logic [ENTRY_SHIFT-1:0] addr_lsb;

  assign addr_lsb = out_addr[ENTRY_SHIFT-1:0];

  `ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)
  `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_hold_payload, clk, rst_n, out_valid && !out_ready, $stable({out_kind, out_addr}))
  `ASSERT_IMPLY(a_fault_zero, clk, rst_n, out_valid && out_kind == KIND_FAULT, out_addr == '0)
  `ASSERT_IMPLY(a_read_aligned, clk, rst_n, out_valid && out_kind == KIND_READ, addr_lsb == '0)

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.out_kind),
  .out_addr  (out_ch.out_addr)
);
